>>> hw/rtl/hgg_pkg.sv
// ----------------------------------------------------------------------------
// hgg_pkg
// Shared constants for the hex grid geometry unit: direction codes and
// fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package hgg_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int DIR_BITS  = 3;
    localparam int STEP_BITS = 15;

    // direction codes
    localparam logic [DIR_BITS-1:0] DIR_N    = 3'd0;
    localparam logic [DIR_BITS-1:0] DIR_NE   = 3'd1;
    localparam logic [DIR_BITS-1:0] DIR_SE   = 3'd2;
    localparam logic [DIR_BITS-1:0] DIR_S    = 3'd3;
    localparam logic [DIR_BITS-1:0] DIR_SW   = 3'd4;
    localparam logic [DIR_BITS-1:0] DIR_NW   = 3'd5;
    localparam logic [DIR_BITS-1:0] DIR_NONE = 3'd6;

endpackage

`default_nettype wire

>>> hw/rtl/hgg_prep.sv
// ----------------------------------------------------------------------------
// hgg_prep
// First pipeline stage: coordinate differences, column parity flags and
// the stepped cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hgg_prep #(
    parameter int COORD_BITS = hgg_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      first_x,
    input  wire logic signed [COORD_BITS-1:0]      first_y,
    input  wire logic signed [COORD_BITS-1:0]      second_x,
    input  wire logic signed [COORD_BITS-1:0]      second_y,
    input  wire logic [hgg_pkg::DIR_BITS-1:0]      step_dir,
    input  wire logic [hgg_pkg::STEP_BITS-1:0]     step_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [COORD_BITS:0]             dx,
    output logic signed [COORD_BITS:0]             dy,
    output logic                                   ax_odd,
    output logic                                   bx_odd,
    output logic                                   par_adj,
    output logic signed [COORD_BITS:0]             sx,
    output logic signed [COORD_BITS:0]             sy,
    output logic                                   sv
);

    localparam int C  = COORD_BITS;
    localparam int SW = (C >= hgg_pkg::STEP_BITS) ? C + 2 : hgg_pkg::STEP_BITS + 2;

    logic                     valid_reg;
    logic                     load;
    logic signed [SW-1:0]     ax_w;
    logic signed [SW-1:0]     ay_w;
    logic [SW-1:0]            n_w;
    logic [SW-1:0]            half_up;
    logic [SW-1:0]            half_dn;
    logic signed [SW-1:0]     sx_w;
    logic signed [SW-1:0]     sy_w;
    logic signed [C:0]        dx_next, dy_next, sx_next, sy_next;
    logic                     sv_next, par_adj_next;
    logic signed [C:0]        dx_reg, dy_reg, sx_reg, sy_reg;
    logic                     ax_odd_reg, bx_odd_reg, par_adj_reg, sv_reg;

    // handshake: stage takes a request when empty or draining
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // differences B minus A
    always_comb
    begin
        dx_next = {second_x[C-1], second_x} - {first_x[C-1], first_x};
        dy_next = {second_y[C-1], second_y} - {first_y[C-1], first_y};
        // positive odd A column against even B column, truncating parity
        par_adj_next = !second_x[0] && first_x[0] && !first_x[C-1];
    end

    // stepped cell
    always_comb
    begin
        ax_w    = {{(SW-C){first_x[C-1]}}, first_x};
        ay_w    = {{(SW-C){first_y[C-1]}}, first_y};
        n_w     = {{(SW-hgg_pkg::STEP_BITS){1'b0}}, step_count};
        half_up = (n_w + {{(SW-1){1'b0}}, 1'b1}) >> 1;
        half_dn = n_w >> 1;
        sx_w    = '0;
        sy_w    = '0;
        sv_next = 1'b1;
        case (step_dir)
            hgg_pkg::DIR_N:
            begin
                sx_w = ax_w;
                sy_w = ay_w - $signed(n_w);
            end
            hgg_pkg::DIR_S:
            begin
                sx_w = ax_w;
                sy_w = ay_w + $signed(n_w);
            end
            hgg_pkg::DIR_SE:
            begin
                sx_w = ax_w + $signed(n_w);
                sy_w = ay_w + $signed(first_x[0] ? half_up : half_dn);
            end
            hgg_pkg::DIR_SW:
            begin
                sx_w = ax_w - $signed(n_w);
                sy_w = ay_w + $signed(first_x[0] ? half_up : half_dn);
            end
            hgg_pkg::DIR_NE:
            begin
                sx_w = ax_w + $signed(n_w);
                sy_w = ay_w - $signed(first_x[0] ? half_dn : half_up);
            end
            hgg_pkg::DIR_NW:
            begin
                sx_w = ax_w - $signed(n_w);
                sy_w = ay_w - $signed(first_x[0] ? half_dn : half_up);
            end
            default:
            begin
                sv_next = 1'b0;
            end
        endcase
        sx_next = sx_w[C:0];
        sy_next = sy_w[C:0];
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            ax_odd_reg  <= first_x[0];
            bx_odd_reg  <= second_x[0];
            par_adj_reg <= par_adj_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            sv_reg      <= sv_next;
        end
    end

    assign out_valid = valid_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign ax_odd    = ax_odd_reg;
    assign bx_odd    = bx_odd_reg;
    assign par_adj   = par_adj_reg;
    assign sx        = sx_reg;
    assign sy        = sy_reg;
    assign sv        = sv_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hgg_measure.sv
// ----------------------------------------------------------------------------
// hgg_measure
// Second pipeline stage: distance terms, adjacency and the two diagonal
// offsets used for the direction from A to B.
// ----------------------------------------------------------------------------
`default_nettype none

module hgg_measure #(
    parameter int COORD_BITS = hgg_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS:0]   dx,
    input  wire logic signed [COORD_BITS:0]   dy,
    input  wire logic                         ax_odd,
    input  wire logic                         bx_odd,
    input  wire logic                         par_adj,
    input  wire logic signed [COORD_BITS:0]   sx_in,
    input  wire logic signed [COORD_BITS:0]   sy_in,
    input  wire logic                         sv_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [COORD_BITS:0]               hd,
    output logic [COORD_BITS+1:0]             alt,
    output logic                              adj,
    output logic                              same,
    output logic                              dx_pos,
    output logic                              dy_pos,
    output logic signed [COORD_BITS+2:0]      swne,
    output logic signed [COORD_BITS+2:0]      senw,
    output logic signed [COORD_BITS:0]        sx_out,
    output logic signed [COORD_BITS:0]        sy_out,
    output logic                              sv_out
);

    localparam int C = COORD_BITS;

    logic                  valid_reg;
    logic                  load;
    logic [C:0]            hd_next;
    logic [C:0]            dya;
    logic                  dy_gt, dy_lt, vp;
    logic [C+1:0]          alt_next;
    logic                  dx_zero, dx_one, adj_next;
    logic signed [C+1:0]   dyt, dx2, t_sw, t_se, h_sw, h_se;
    logic                  bias, dyt_pos, same_next, dx_pos_next;
    logic signed [C+2:0]   swne_next, senw_next;
    logic [C:0]            hd_reg;
    logic [C+1:0]          alt_reg;
    logic                  adj_reg, same_reg, dx_pos_reg, dy_pos_reg, sv_reg;
    logic signed [C+2:0]   swne_reg, senw_reg;
    logic signed [C:0]     sx_reg, sy_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // hex distance terms
    always_comb
    begin
        hd_next  = dx[C] ? (~dx + 1'b1) : dx;
        dya      = dy[C] ? (~dy + 1'b1) : dy;
        dy_gt    = !dy[C] && (dy != '0);
        dy_lt    = dy[C];
        vp       = (!ax_odd && bx_odd && dy_gt) || (!bx_odd && ax_odd && dy_lt);
        alt_next = {1'b0, dya} + {{(C+1){1'b0}}, vp} + {2'b00, hd_next[C:1]};
    end

    // neighbour test
    always_comb
    begin
        dx_zero = (dx == '0);
        dx_one  = (hd_next == {{C{1'b0}}, 1'b1});
        if (dy == '1)
        begin
            adj_next = dx_zero || (dx_one && !ax_odd);
        end
        else if (dy == {{C{1'b0}}, 1'b1})
        begin
            adj_next = dx_zero || (dx_one && !bx_odd);
        end
        else if (dy == '0)
        begin
            adj_next = dx_one;
        end
        else
        begin
            adj_next = 1'b0;
        end
    end

    // diagonal offsets, truncating halves
    always_comb
    begin
        dyt         = {dy[C], dy} - {{(C+1){1'b0}}, par_adj};
        dx2         = {dx[C], dx};
        dyt_pos     = !dyt[C+1] && (dyt != '0);
        bias        = !dyt_pos;
        t_sw        = dx2 + {{(C+1){1'b0}}, bias};
        t_se        = dx2 - {{(C+1){1'b0}}, bias};
        h_sw        = (t_sw >>> 1) + $signed({{(C+1){1'b0}}, t_sw[C+1] & t_sw[0]});
        h_se        = (t_se >>> 1) + $signed({{(C+1){1'b0}}, t_se[C+1] & t_se[0]});
        swne_next   = {dyt[C+1], dyt} + {h_sw[C+1], h_sw};
        senw_next   = {dyt[C+1], dyt} - {h_se[C+1], h_se};
        same_next   = dx_zero && (dyt == '0);
        dx_pos_next = !dx[C] && !dx_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hd_reg     <= hd_next;
            alt_reg    <= alt_next;
            adj_reg    <= adj_next;
            same_reg   <= same_next;
            dx_pos_reg <= dx_pos_next;
            dy_pos_reg <= dyt_pos;
            swne_reg   <= swne_next;
            senw_reg   <= senw_next;
            sx_reg     <= sx_in;
            sy_reg     <= sy_in;
            sv_reg     <= sv_in;
        end
    end

    assign out_valid = valid_reg;
    assign hd        = hd_reg;
    assign alt       = alt_reg;
    assign adj       = adj_reg;
    assign same      = same_reg;
    assign dx_pos    = dx_pos_reg;
    assign dy_pos    = dy_pos_reg;
    assign swne      = swne_reg;
    assign senw      = senw_reg;
    assign sx_out    = sx_reg;
    assign sy_out    = sy_reg;
    assign sv_out    = sv_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hgg_decide.sv
// ----------------------------------------------------------------------------
// hgg_decide
// Third pipeline stage and output register: final distance, direction
// choice from the three line distances.
// ----------------------------------------------------------------------------
`default_nettype none

module hgg_decide #(
    parameter int COORD_BITS = hgg_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [COORD_BITS:0]          hd,
    input  wire logic [COORD_BITS+1:0]        alt,
    input  wire logic                         adj,
    input  wire logic                         same,
    input  wire logic                         dx_pos,
    input  wire logic                         dy_pos,
    input  wire logic signed [COORD_BITS+2:0] swne,
    input  wire logic signed [COORD_BITS+2:0] senw,
    input  wire logic signed [COORD_BITS:0]   sx_in,
    input  wire logic signed [COORD_BITS:0]   sy_in,
    input  wire logic                         sv_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [COORD_BITS:0]               hex_distance,
    output logic                              is_adjacent,
    output logic [hgg_pkg::DIR_BITS-1:0]      toward_dir,
    output logic signed [COORD_BITS:0]        stepped_x,
    output logic signed [COORD_BITS:0]        stepped_y,
    output logic                              stepped_valid
);

    localparam int C = COORD_BITS;

    logic                          valid_reg;
    logic                          load;
    logic [C+2:0]                  d_swne, d_senw, d_ns, best;
    logic [hgg_pkg::DIR_BITS-1:0]  dir_next;
    logic [C+1:0]                  hd_w;
    logic [C:0]                    hex_next;
    logic [C:0]                    hex_reg;
    logic                          adj_reg, sv_reg;
    logic [hgg_pkg::DIR_BITS-1:0]  dir_reg;
    logic signed [C:0]             sx_reg, sy_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // hex distance is the larger of the two measures
    always_comb
    begin
        hd_w     = {1'b0, hd};
        hex_next = (hd_w > alt) ? hd : alt[C:0];
    end

    // direction: north-south line first, then the two diagonals
    always_comb
    begin
        d_swne = swne[C+2] ? (~swne + 1'b1) : swne;
        d_senw = senw[C+2] ? (~senw + 1'b1) : senw;
        d_ns   = {2'b00, hd};
        best   = d_ns;
        dir_next = dy_pos ? hgg_pkg::DIR_S : hgg_pkg::DIR_N;
        if (d_senw < d_ns)
        begin
            dir_next = dx_pos ? hgg_pkg::DIR_SE : hgg_pkg::DIR_NW;
            best     = d_senw;
        end
        if (d_swne < best)
        begin
            dir_next = dx_pos ? hgg_pkg::DIR_NE : hgg_pkg::DIR_SW;
        end
        if (same)
        begin
            dir_next = hgg_pkg::DIR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hex_reg <= hex_next;
            adj_reg <= adj;
            dir_reg <= dir_next;
            sx_reg  <= sx_in;
            sy_reg  <= sy_in;
            sv_reg  <= sv_in;
        end
    end

    assign out_valid     = valid_reg;
    assign hex_distance  = hex_reg;
    assign is_adjacent   = adj_reg;
    assign toward_dir    = dir_reg;
    assign stepped_x     = sx_reg;
    assign stepped_y     = sy_reg;
    assign stepped_valid = sv_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hex_grid_geometry_unit_core.sv
// ----------------------------------------------------------------------------
// hex_grid_geometry_unit_core
// Distance, adjacency, direction and stepping on an odd-column-low offset
// hex grid, as a three-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel   signals                        carries
//  --------  -----------------------------  ---------------------------------
//  in        in_valid / in_ready            cells A and B, step dir and count
//  out       out_valid / out_ready          distance, adjacency, dir, step
//
//  One request per cycle while out is not stalled; a result passes the prep,
//  measure and decide registers in that order before it is on the output.
//  Every stage holds a valid bit and advances when empty or when the stage
//  after it advances, so a stall at out holds all data in place.
//  Reset clears the valid bits only; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_grid_geometry_unit_core #(
    parameter int COORD_BITS = hgg_pkg::COORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [COORD_BITS-1:0]   first_x,
    input  wire logic signed [COORD_BITS-1:0]   first_y,
    input  wire logic signed [COORD_BITS-1:0]   second_x,
    input  wire logic signed [COORD_BITS-1:0]   second_y,
    input  wire logic [hgg_pkg::DIR_BITS-1:0]   step_dir,
    input  wire logic [hgg_pkg::STEP_BITS-1:0]  step_count,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [COORD_BITS:0]                 hex_distance,
    output logic                                is_adjacent,
    output logic [hgg_pkg::DIR_BITS-1:0]        toward_dir,
    output logic signed [COORD_BITS:0]          stepped_x,
    output logic signed [COORD_BITS:0]          stepped_y,
    output logic                                stepped_valid
);

    localparam int C = COORD_BITS;

    // prep to measure
    logic                 p_valid, p_ready;
    logic signed [C:0]    p_dx, p_dy, p_sx, p_sy;
    logic                 p_ax_odd, p_bx_odd, p_par_adj, p_sv;

    // measure to decide
    logic                 m_valid, m_ready;
    logic [C:0]           m_hd;
    logic [C+1:0]         m_alt;
    logic                 m_adj, m_same, m_dx_pos, m_dy_pos, m_sv;
    logic signed [C+2:0]  m_swne, m_senw;
    logic signed [C:0]    m_sx, m_sy;

    hgg_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .step_dir   (step_dir),
        .step_count (step_count),
        .out_valid  (p_valid),
        .out_ready  (p_ready),
        .dx         (p_dx),
        .dy         (p_dy),
        .ax_odd     (p_ax_odd),
        .bx_odd     (p_bx_odd),
        .par_adj    (p_par_adj),
        .sx         (p_sx),
        .sy         (p_sy),
        .sv         (p_sv)
    );

    hgg_measure #(
        .COORD_BITS (COORD_BITS)
    ) u_measure (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_ready  (p_ready),
        .dx        (p_dx),
        .dy        (p_dy),
        .ax_odd    (p_ax_odd),
        .bx_odd    (p_bx_odd),
        .par_adj   (p_par_adj),
        .sx_in     (p_sx),
        .sy_in     (p_sy),
        .sv_in     (p_sv),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .hd        (m_hd),
        .alt       (m_alt),
        .adj       (m_adj),
        .same      (m_same),
        .dx_pos    (m_dx_pos),
        .dy_pos    (m_dy_pos),
        .swne      (m_swne),
        .senw      (m_senw),
        .sx_out    (m_sx),
        .sy_out    (m_sy),
        .sv_out    (m_sv)
    );

    hgg_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (m_valid),
        .in_ready      (m_ready),
        .hd            (m_hd),
        .alt           (m_alt),
        .adj           (m_adj),
        .same          (m_same),
        .dx_pos        (m_dx_pos),
        .dy_pos        (m_dy_pos),
        .swne          (m_swne),
        .senw          (m_senw),
        .sx_in         (m_sx),
        .sy_in         (m_sy),
        .sv_in         (m_sv),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hex_distance  (hex_distance),
        .is_adjacent   (is_adjacent),
        .toward_dir    (toward_dir),
        .stepped_x     (stepped_x),
        .stepped_y     (stepped_y),
        .stepped_valid (stepped_valid)
    );

endmodule

`default_nettype wire
